// ===== rtl/core/kwt_pkg.sv =====
// kwt_pkg: shared types, codes and character constants of the keyword/number tokenizer.
// No dependencies; every other file of the tokenizer uses it.
`timescale 1ns / 1ps

package kwt_pkg;

    localparam int NUMBER_BITS_DEF = 31;
    localparam int LINE_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_UPPER_L = 8'h4C;
    localparam logic [7:0] CH_LOWER_M = 8'h6D;
    localparam logic [7:0] CH_LOWER_G = 8'h67;
    localparam logic [7:0] CH_LOWER_I = 8'h69;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_LOWER_O = 8'h6F;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] BAD_AT_END = 8'hFF;

    typedef enum logic [4:0] {
        K_EOF     = 5'd0,
        K_NUM     = 5'd1,
        K_PLUS    = 5'd2,
        K_MINUS   = 5'd3,
        K_TIMES   = 5'd4,
        K_DIVIDE  = 5'd5,
        K_POWER   = 5'd6,
        K_EQUALS  = 5'd7,
        K_LPAREN  = 5'd8,
        K_RPAREN  = 5'd9,
        K_LBRACK  = 5'd10,
        K_RBRACK  = 5'd11,
        K_M       = 5'd12,
        K_GOTO    = 5'd13,
        K_IF      = 5'd14,
        K_PRINT   = 5'd15,
        K_L       = 5'd16,
        K_COLON   = 5'd17,
        K_ERROR   = 5'd18
    } t_kind;

    typedef enum logic [3:0] {
        C_DIGIT,
        C_SPACE,
        C_NEWLINE,
        C_STAR,
        C_G,
        C_I,
        C_P,
        C_SINGLE,
        C_BAD
    } t_cls;

    typedef enum logic [11:0] {
        PH_IDLE = 12'b0000_0000_0001,
        PH_NUM  = 12'b0000_0000_0010,
        PH_STAR = 12'b0000_0000_0100,
        PH_G    = 12'b0000_0000_1000,
        PH_GO   = 12'b0000_0001_0000,
        PH_GOT  = 12'b0000_0010_0000,
        PH_I    = 12'b0000_0100_0000,
        PH_P    = 12'b0000_1000_0000,
        PH_PR   = 12'b0001_0000_0000,
        PH_PRI  = 12'b0010_0000_0000,
        PH_PRIN = 12'b0100_0000_0000,
        PH_HALT = 12'b1000_0000_0000
    } t_phase;

    // One classified character as it travels from the front end to the back end.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       eoi;
        t_cls       cls;
        t_kind      kind;
    } t_item;

endpackage

// ===== rtl/core/kwt_if.sv =====
// kwt_in_if and kwt_out_if: valid/ready channels of the tokenizer.
// Depends on kwt_pkg for default field widths.
`timescale 1ns / 1ps

interface kwt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source(output valid, char_byte, end_of_input, input ready);
    modport sink(input valid, char_byte, end_of_input, output ready);
endinterface

interface kwt_out_if #(
    parameter int NUMBER_BITS = kwt_pkg::NUMBER_BITS_DEF,
    parameter int LINE_BITS   = kwt_pkg::LINE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [4:0]             token_kind;
    logic [NUMBER_BITS-1:0] number_value;
    logic [LINE_BITS-1:0]   line_number;
    logic [7:0]             bad_char;
    logic                   last_of_run;

    modport source(output valid, token_kind, number_value, line_number, bad_char,
                   last_of_run, input ready);
    modport sink(input valid, token_kind, number_value, line_number, bad_char,
                 last_of_run, output ready);
endinterface

// ===== rtl/core/kwt_front.sv =====
// kwt_front: accepts input characters and classifies them for the back end.
// Depends on kwt_pkg and kwt_in_if.
`timescale 1ns / 1ps

module kwt_front (
    kwt_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output kwt_pkg::t_item  o_item
);
    import kwt_pkg::*;

    t_cls  cls;
    t_kind kind;

    always_comb begin
        cls  = C_SINGLE;
        kind = K_EOF;
        case (i_in.char_byte)
            CH_SPACE:   cls = C_SPACE;
            CH_NEWLINE: cls = C_NEWLINE;
            CH_STAR:    cls = C_STAR;
            CH_LOWER_G: cls = C_G;
            CH_LOWER_I: cls = C_I;
            CH_LOWER_P: cls = C_P;
            CH_PLUS:    kind = K_PLUS;
            CH_MINUS:   kind = K_MINUS;
            CH_SLASH:   kind = K_DIVIDE;
            CH_EQUALS:  kind = K_EQUALS;
            CH_LPAREN:  kind = K_LPAREN;
            CH_RPAREN:  kind = K_RPAREN;
            CH_LBRACK:  kind = K_LBRACK;
            CH_RBRACK:  kind = K_RBRACK;
            CH_LOWER_M: kind = K_M;
            CH_UPPER_L: kind = K_L;
            CH_COLON:   kind = K_COLON;
            default: begin
                if (i_in.char_byte inside {[CH_ZERO:CH_NINE]}) begin
                    cls = C_DIGIT;
                end else begin
                    cls  = C_BAD;
                    kind = K_ERROR;
                end
            end
        endcase
    end

    assign i_in.ready       = !i_full;
    assign o_push           = i_in.valid && !i_full;
    assign o_item.char_byte = i_in.char_byte;
    assign o_item.eoi       = i_in.end_of_input;
    assign o_item.cls       = cls;
    assign o_item.kind      = kind;

endmodule

// ===== rtl/core/kwt_fifo.sv =====
// kwt_fifo: short queue of classified items between the front and back ends.
// Depends on kwt_pkg.
`timescale 1ns / 1ps

module kwt_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kwt_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output kwt_pkg::t_item  o_item
);
    import kwt_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_item               r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [PTR_BITS:0]   r_cnt;
    logic [PTR_BITS:0]   n_cnt;

    assign o_full  = (r_cnt == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/kwt_back.sv =====
// kwt_back: scanner state, number accumulation, keyword matching and result staging.
// Depends on kwt_pkg and kwt_out_if.
`timescale 1ns / 1ps

module kwt_back #(
    parameter int NUMBER_BITS = kwt_pkg::NUMBER_BITS_DEF,
    parameter int LINE_BITS   = kwt_pkg::LINE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  kwt_pkg::t_item  i_item,
    output logic            o_pop,
    kwt_out_if.source       o_out
);
    import kwt_pkg::*;

    localparam logic [NUMBER_BITS-1:0] NUM_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    t_phase                 r_phase, n_phase;
    logic [NUMBER_BITS-1:0] r_acc, n_acc;
    logic [LINE_BITS-1:0]   r_line, n_line;

    // Two output slots: the first drives the port, the second holds a follow-up result.
    logic                   r_v0, r_v1;
    t_kind                  r_kind0, r_kind1;
    logic [NUMBER_BITS-1:0] r_val0;
    logic [LINE_BITS-1:0]   r_line0, r_line1;
    logic [7:0]             r_bad0, r_bad1;
    logic                   r_last0;

    t_phase                 idle_phase;
    logic [NUMBER_BITS-1:0] idle_acc;
    logic [LINE_BITS-1:0]   idle_line;
    logic                   idle_v;
    t_kind                  idle_kind;
    logic [7:0]             idle_bad;

    logic                   pre_v;
    t_kind                  pre_kind;
    logic [NUMBER_BITS-1:0] pre_val;
    logic                   tail_v;
    t_kind                  tail_kind;
    logic [7:0]             tail_bad;

    logic [7:0]             kw_exp;
    t_kind                  kw_done;
    logic                   kw_last;
    t_phase                 kw_next;

    logic [NUMBER_BITS+3:0] acc_sum;
    logic [NUMBER_BITS-1:0] acc_sat;

    // acc * 10 + digit, with the top four bits flagging overflow.
    assign acc_sum = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                   + (NUMBER_BITS+4)'(i_item.char_byte[3:0]);
    assign acc_sat = (acc_sum[NUMBER_BITS+3:NUMBER_BITS] != '0) ? NUM_MAX
                   : acc_sum[NUMBER_BITS-1:0];

    always_comb begin
        kw_exp  = CH_LOWER_O;
        kw_done = K_EOF;
        kw_last = 1'b0;
        kw_next = PH_HALT;
        case (r_phase)
            PH_G:    kw_next = PH_GO;
            PH_GO: begin
                kw_exp  = CH_LOWER_T;
                kw_next = PH_GOT;
            end
            PH_GOT: begin
                kw_done = K_GOTO;
                kw_last = 1'b1;
            end
            PH_I: begin
                kw_exp  = CH_LOWER_F;
                kw_done = K_IF;
                kw_last = 1'b1;
            end
            PH_P: begin
                kw_exp  = CH_LOWER_R;
                kw_next = PH_PR;
            end
            PH_PR: begin
                kw_exp  = CH_LOWER_I;
                kw_next = PH_PRI;
            end
            PH_PRI: begin
                kw_exp  = CH_LOWER_N;
                kw_next = PH_PRIN;
            end
            PH_PRIN: begin
                kw_exp  = CH_LOWER_T;
                kw_done = K_PRINT;
                kw_last = 1'b1;
            end
            default: ;
        endcase
    end

    // What a character does when no token is pending.
    always_comb begin
        idle_phase = PH_IDLE;
        idle_acc   = '0;
        idle_line  = r_line;
        idle_v     = 1'b0;
        idle_kind  = K_EOF;
        idle_bad   = '0;
        case (i_item.cls)
            C_DIGIT: begin
                idle_phase = PH_NUM;
                idle_acc   = NUMBER_BITS'(i_item.char_byte[3:0]);
            end
            C_NEWLINE: begin
                if (r_line != LINE_MAX) begin
                    idle_line = r_line + 1'b1;
                end
            end
            C_STAR:   idle_phase = PH_STAR;
            C_G:      idle_phase = PH_G;
            C_I:      idle_phase = PH_I;
            C_P:      idle_phase = PH_P;
            C_SINGLE: begin
                idle_v    = 1'b1;
                idle_kind = i_item.kind;
            end
            C_BAD: begin
                idle_v     = 1'b1;
                idle_kind  = K_ERROR;
                idle_bad   = i_item.char_byte;
                idle_phase = PH_HALT;
            end
            default: ;
        endcase
    end

    always_comb begin
        pre_v     = 1'b0;
        pre_kind  = K_NUM;
        pre_val   = '0;
        tail_v    = idle_v;
        tail_kind = idle_kind;
        tail_bad  = idle_bad;
        n_phase   = idle_phase;
        n_acc     = idle_acc;
        n_line    = idle_line;
        if (r_phase == PH_HALT) begin
            tail_v  = 1'b0;
            n_phase = r_phase;
            n_acc   = r_acc;
            n_line  = r_line;
        end else if (i_item.eoi) begin
            // Flush number or star, give eof, start over; mid-keyword: error and halt.
            tail_v    = 1'b1;
            tail_kind = K_EOF;
            tail_bad  = '0;
            n_phase   = PH_IDLE;
            n_acc     = '0;
            n_line    = LINE_BITS'(1);
            case (r_phase)
                PH_IDLE: ;
                PH_NUM: begin
                    pre_v   = 1'b1;
                    pre_val = r_acc;
                end
                PH_STAR: begin
                    pre_v    = 1'b1;
                    pre_kind = K_TIMES;
                end
                default: begin
                    tail_kind = K_ERROR;
                    tail_bad  = BAD_AT_END;
                    n_phase   = PH_HALT;
                    n_acc     = r_acc;
                    n_line    = r_line;
                end
            endcase
        end else begin
            case (r_phase)
                PH_IDLE: ;
                PH_NUM: begin
                    if (i_item.cls == C_DIGIT) begin
                        tail_v  = 1'b0;
                        n_phase = PH_NUM;
                        n_acc   = acc_sat;
                        n_line  = r_line;
                    end else begin
                        pre_v   = 1'b1;
                        pre_val = r_acc;
                    end
                end
                PH_STAR: begin
                    if (i_item.cls == C_STAR) begin
                        tail_v    = 1'b1;
                        tail_kind = K_POWER;
                        tail_bad  = '0;
                        n_phase   = PH_IDLE;
                        n_acc     = r_acc;
                        n_line    = r_line;
                    end else begin
                        pre_v    = 1'b1;
                        pre_kind = K_TIMES;
                    end
                end
                default: begin
                    n_acc  = r_acc;
                    n_line = r_line;
                    if (i_item.char_byte == kw_exp) begin
                        tail_v    = kw_last;
                        tail_kind = kw_done;
                        tail_bad  = '0;
                        n_phase   = kw_last ? PH_IDLE : kw_next;
                    end else begin
                        tail_v    = 1'b1;
                        tail_kind = K_ERROR;
                        tail_bad  = i_item.char_byte;
                        n_phase   = PH_HALT;
                    end
                end
            endcase
        end
    end

    // An item leaves the queue only when both of its possible results have room.
    assign o_pop = i_valid && !r_v1 && (!r_v0 || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_line  <= LINE_BITS'(1);
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
        end else begin
            if (r_v0 && o_out.ready) begin
                r_v0 <= r_v1;
                r_v1 <= 1'b0;
            end
            if (o_pop) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_line  <= n_line;
                if (pre_v || tail_v) begin
                    r_v0 <= 1'b1;
                end
                if (pre_v && tail_v) begin
                    r_v1 <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (pre_v || tail_v)) begin
            r_kind0 <= pre_v ? pre_kind : tail_kind;
            r_val0  <= pre_v ? pre_val : '0;
            r_line0 <= r_line;
            r_bad0  <= pre_v ? 8'h00 : tail_bad;
            r_last0 <= !(pre_v && tail_v);
            r_kind1 <= tail_kind;
            r_line1 <= r_line;
            r_bad1  <= tail_bad;
        end else if (r_v0 && o_out.ready && r_v1) begin
            r_kind0 <= r_kind1;
            r_val0  <= '0;
            r_line0 <= r_line1;
            r_bad0  <= r_bad1;
            r_last0 <= 1'b1;
        end
    end

    assign o_out.valid        = r_v0;
    assign o_out.token_kind   = r_kind0;
    assign o_out.number_value = r_val0;
    assign o_out.line_number  = r_line0;
    assign o_out.bad_char     = r_bad0;
    assign o_out.last_of_run  = r_last0;

`ifndef NO_ASSERTIONS
    a_slots_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("second result slot filled while first is empty");

    a_first_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last_of_run) |-> r_v1)
        else $error("result not last of its run but no follow-up staged");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_phase == PH_HALT) |-> !(pre_v || tail_v))
        else $error("halted scanner produced a result");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter wrapped to zero");
`endif

endmodule

// ===== rtl/core/keyword_number_tokenizer.sv =====
// A result is registered in the queue, then in the scanner's output slots, after its character is accepted.
// Throughput: one character per cycle while the queue is not full; a character that causes two tokens holds
// back the next character until the first token is taken, and a four-entry queue absorbs that and output stalls.
// Reset (synchronous, active low) empties the queue and output slots, returns the scanner
// to idle with the number cleared and the line counter at one.
// keyword_number_tokenizer: top level; depends on kwt_pkg, kwt_if, kwt_front, kwt_fifo, kwt_back.
`timescale 1ns / 1ps

module keyword_number_tokenizer #(
    parameter int NUMBER_BITS = kwt_pkg::NUMBER_BITS_DEF,
    parameter int LINE_BITS   = kwt_pkg::LINE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kwt_in_if.sink     i_in,
    kwt_out_if.source  o_out
);
    import kwt_pkg::*;

    logic  push, full, pop, head_valid;
    t_item push_item, head_item;

    kwt_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (push_item)
    );

    kwt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    kwt_back #(
        .NUMBER_BITS (NUMBER_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== test/keyword_number_tokenizer_test.sv =====
// keyword_number_tokenizer_test: self-checking testbench of the character tokenizer.
// A scoreboard class predicts the token stream; depends on kwt_pkg, kwt_if and the RTL.
`timescale 1ns / 1ps

module keyword_number_tokenizer_test;
    import kwt_pkg::*;

    localparam int NB          = NUMBER_BITS_DEF;
    localparam int LB          = LINE_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [4:0]    kind;
        logic [NB-1:0] value;
        logic [LB-1:0] line;
        logic [7:0]    bad;
        logic          last;
    } t_token;

    class token_scoreboard;
        t_phase        phase;
        logic [NB-1:0] acc;
        logic [LB-1:0] line;
        t_token        run[$];
        t_token        due[$];
        int            errors;
        int            checked;

        function void restart();
            phase = PH_IDLE;
            acc   = '0;
            line  = LB'(1);
        endfunction

        function new();
            restart();
            errors  = 0;
            checked = 0;
        endfunction

        function void add_token(t_kind k, logic [NB-1:0] v, logic [7:0] b);
            t_token t;
            t.kind  = k;
            t.value = v;
            t.line  = line;
            t.bad   = b;
            t.last  = 1'b0;
            run.push_back(t);
        endfunction

        // The tokens caused by one item go out together, the last one flagged.
        function void publish();
            if (run.size() == 0) return;
            run[run.size()-1].last = 1'b1;
            foreach (run[i]) due.push_back(run[i]);
        endfunction

        function void note_char(logic [7:0] c, logic eoi);
            logic [NB-1:0] digit;
            logic [NB-1:0] num_max;
            t_phase        next_phase;
            logic [7:0]    want;
            t_kind         done_kind;
            bit            completes;
            run.delete();
            digit   = NB'(8'(c - CH_ZERO));
            num_max = '1;
            if (phase == PH_HALT) return;

            if (eoi) begin
                if (phase == PH_NUM) begin
                    add_token(K_NUM, acc, 8'd0);
                end else if (phase == PH_STAR) begin
                    add_token(K_TIMES, '0, 8'd0);
                end else if (phase != PH_IDLE) begin
                    add_token(K_ERROR, '0, BAD_AT_END);
                    phase = PH_HALT;
                end
                if (phase != PH_HALT) begin
                    add_token(K_EOF, '0, 8'd0);
                    restart();
                end
                publish();
                return;
            end

            case (phase)
                PH_IDLE: ;
                PH_NUM: begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        if (acc > (num_max - digit) / 10) acc = num_max;
                        else acc = NB'(acc * 10 + digit);
                        return;
                    end
                    add_token(K_NUM, acc, 8'd0);
                    acc   = '0;
                    phase = PH_IDLE;
                end
                PH_STAR: begin
                    phase = PH_IDLE;
                    if (c == CH_STAR) begin
                        add_token(K_POWER, '0, 8'd0);
                        publish();
                        return;
                    end
                    add_token(K_TIMES, '0, 8'd0);
                end
                default: begin
                    // Inside a keyword only the next letter is accepted.
                    completes  = 1'b0;
                    done_kind  = K_EOF;
                    next_phase = PH_IDLE;
                    case (phase)
                        PH_G:    begin want = CH_LOWER_O; next_phase = PH_GO; end
                        PH_GO:   begin want = CH_LOWER_T; next_phase = PH_GOT; end
                        PH_GOT:  begin want = CH_LOWER_O; completes = 1'b1; done_kind = K_GOTO; end
                        PH_I:    begin want = CH_LOWER_F; completes = 1'b1; done_kind = K_IF; end
                        PH_P:    begin want = CH_LOWER_R; next_phase = PH_PR; end
                        PH_PR:   begin want = CH_LOWER_I; next_phase = PH_PRI; end
                        PH_PRI:  begin want = CH_LOWER_N; next_phase = PH_PRIN; end
                        default: begin want = CH_LOWER_T; completes = 1'b1; done_kind = K_PRINT; end
                    endcase
                    if (c != want) begin
                        add_token(K_ERROR, '0, c);
                        phase = PH_HALT;
                    end else if (completes) begin
                        add_token(done_kind, '0, 8'd0);
                        phase = PH_IDLE;
                    end else begin
                        phase = next_phase;
                    end
                    publish();
                    return;
                end
            endcase

            if (c >= CH_ZERO && c <= CH_NINE) begin
                acc   = digit;
                phase = PH_NUM;
            end else begin
                case (c)
                    CH_SPACE:   ;
                    CH_NEWLINE: if (line != '1) line = line + 1'b1;
                    CH_STAR:    phase = PH_STAR;
                    CH_LOWER_G: phase = PH_G;
                    CH_LOWER_I: phase = PH_I;
                    CH_LOWER_P: phase = PH_P;
                    CH_PLUS:    add_token(K_PLUS, '0, 8'd0);
                    CH_MINUS:   add_token(K_MINUS, '0, 8'd0);
                    CH_SLASH:   add_token(K_DIVIDE, '0, 8'd0);
                    CH_EQUALS:  add_token(K_EQUALS, '0, 8'd0);
                    CH_LPAREN:  add_token(K_LPAREN, '0, 8'd0);
                    CH_RPAREN:  add_token(K_RPAREN, '0, 8'd0);
                    CH_LBRACK:  add_token(K_LBRACK, '0, 8'd0);
                    CH_RBRACK:  add_token(K_RBRACK, '0, 8'd0);
                    CH_LOWER_M: add_token(K_M, '0, 8'd0);
                    CH_UPPER_L: add_token(K_L, '0, 8'd0);
                    CH_COLON:   add_token(K_COLON, '0, 8'd0);
                    default: begin
                        add_token(K_ERROR, '0, c);
                        phase = PH_HALT;
                    end
                endcase
            end
            publish();
        endfunction

        function void check_token(t_token got);
            t_token want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: unexpected token, expected none, got kind %0d value %0d line %0d bad %0d last %0d",
                         $time, got.kind, got.value, got.line, got.bad, got.last);
                return;
            end
            want = due.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                $display("%0t: token mismatch, expected kind %0d value %0d line %0d bad %0d last %0d",
                         $time, want.kind, want.value, want.line, want.bad, want.last);
                $display("%0t:                   got kind %0d value %0d line %0d bad %0d last %0d",
                         $time, got.kind, got.value, got.line, got.bad, got.last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    kwt_in_if                                     in_if ();
    kwt_out_if #(.NUMBER_BITS(NB), .LINE_BITS(LB)) out_if ();

    keyword_number_tokenizer #(
        .NUMBER_BITS(NB),
        .LINE_BITS  (LB)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    token_scoreboard board;
    bit              idle_enable = 1'b1;
    int              chars_sent  = 0;
    int              cycles      = 0;
    string           words[3]    = '{"goto", "if", "print"};
    string           singles     = "+-/=()[]mL:";
    logic [7:0]      odd_bytes[14] = '{8'h00, 8'h09, 8'h21, 8'h23, 8'h2E, 8'h3B, 8'h3F,
                                       8'h40, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h7E, 8'h7F};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic push_char(input logic [7:0] c, input logic eoi);
        int gap;
        gap = idle_enable ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.char_byte    <= c;
        in_if.end_of_input <= eoi;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        board.note_char(c, eoi);
        chars_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
    endtask

    // The byte that travels with the end mark is ignored, so it is random.
    task automatic push_end();
        push_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.due.size() != 0);
    endtask

    // Mostly well-formed token text; adjacent pieces may merge into longer numbers or power.
    task automatic send_token_stream(input int count);
        int target;
        int len;
        target = chars_sent + count;
        while (chars_sent < target) begin
            case ($urandom_range(0, 11))
                0, 1, 2: begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
                    repeat (len) push_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                end
                3:       push_text(words[$urandom_range(0, 2)]);
                4:       repeat ($urandom_range(1, 2)) push_char(CH_STAR, 1'b0);
                5, 6, 7: push_char(singles[$urandom_range(0, 10)], 1'b0);
                8, 9:    repeat ($urandom_range(1, 3)) push_char(CH_SPACE, 1'b0);
                10:      push_char(CH_NEWLINE, 1'b0);
                default: begin
                    if ($urandom_range(0, 3) == 0) push_end();
                    else push_char(CH_SPACE, 1'b0);
                end
            endcase
        end
    endtask

    initial begin : result_sink
        t_token got;
        int     stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = idle_enable ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            got.kind  = out_if.token_kind;
            got.value = out_if.number_value;
            got.line  = out_if.line_number;
            got.bad   = out_if.bad_char;
            got.last  = out_if.last_of_run;
            board.check_token(got);
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d tokens outstanding", cycles, board.due.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int         halt_case;
        int         cut;
        string      word;
        string      halt_note;
        logic [7:0] wrong;
        board = new();
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.char_byte    <= 8'd0;
        in_if.end_of_input <= 1'b0;
        out_if.ready       <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Number extremes and saturation, then a number flushed by the end mark.
        push_text("0 9 2147483647 2147483648\n99999999999");
        push_end();
        // Keywords, power, a number and a star each ended by a token, a star flushed at the end.
        push_text("goto if print**7+-/=()[]mL:*(*");
        push_end();
        push_end();

        // Line counting across several newlines, sent back to back.
        idle_enable = 1'b0;
        push_text("\n\n\n3\n+");
        push_end();
        idle_enable = 1'b1;

        send_token_stream(415);
        drain();
        send_token_stream(415);
        drain();

        // Only one halt is possible per run, since reset is applied once.
        halt_case = $urandom_range(0, 2);
        word      = words[$urandom_range(0, 2)];
        cut       = $urandom_range(1, word.len() - 1);
        case (halt_case)
            0: begin
                halt_note = "unknown character";
                if ($urandom_range(0, 1) == 1) push_char(8'($urandom_range(128, 255)), 1'b0);
                else push_char(odd_bytes[$urandom_range(0, 13)], 1'b0);
            end
            1: begin
                halt_note = "broken keyword";
                push_text(word.substr(0, cut - 1));
                do begin
                    case ($urandom_range(0, 2))
                        0:       wrong = CH_SPACE;
                        1:       wrong = CH_NEWLINE;
                        default: wrong = 8'($urandom_range(0, 255));
                    endcase
                end while (wrong == word[cut]);
                push_char(wrong, 1'b0);
            end
            default: begin
                halt_note = "end of input inside a keyword";
                push_text(word.substr(0, cut - 1));
                push_end();
            end
        endcase
        // Once halted, nothing may come out whatever arrives.
        repeat (40) push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters: directed tokens, line counting, random token text, %s.",
                 chars_sent, halt_note);
        $display("Checked %0d tokens, %0d mismatches.", board.checked, board.errors);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
